// ----- sv/ismg_pkg.sv -----
// Package for the interval set insert-and-merge block.
// Holds sizes, command codes and the structs shared by the cell row and the top level.
// No dependencies.
package ismg_pkg;

	localparam int ENTRIES   = 32;
	localparam int TIME_BITS = 32;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int CNT_W     = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_READ   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_MERGE  = 2'd2,
		OP_ABSORB = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic                 cmp_en;
		cell_op_t             op;
		logic [TIME_BITS-1:0] lo;
		logic [TIME_BITS-1:0] hi;
	} cell_ctl_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] lo;
		logic [TIME_BITS-1:0] hi;
		logic                 after;
		logic                 ov;
	} cell_link_t;

	typedef struct packed {
		logic any_ov;
		logic multi_ov;
	} chain_stat_t;

endpackage

// ----- sv/ismg_cell.sv -----
// One entry of the sorted interval row: stored interval plus its compare flags.
// Depends on ismg_pkg.
module ismg_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  ismg_pkg::cell_ctl_t  ctl,
	input  logic               valid,
	input  ismg_pkg::cell_link_t left,
	input  ismg_pkg::cell_link_t right,
	output ismg_pkg::cell_link_t link
);
	import ismg_pkg::*;

	logic [TIME_BITS-1:0] lo_q;
	logic [TIME_BITS-1:0] hi_q;
	logic                 after_q;
	logic                 ov_q;
	logic [TIME_BITS-1:0] min_lo;
	logic [TIME_BITS-1:0] max_hi;
	logic                 lies_after;

	assign link       = '{lo: lo_q, hi: hi_q, after: after_q, ov: ov_q};
	assign lies_after = ctl.hi < lo_q;
	assign min_lo     = (ctl.lo < lo_q) ? ctl.lo : lo_q;
	assign max_hi     = (ctl.hi > hi_q) ? ctl.hi : hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_q <= 1'b0;
			ov_q    <= 1'b0;
		end else if (ctl.cmp_en) begin
			after_q <= !valid || lies_after;
			ov_q    <= valid && !lies_after && (ctl.lo <= hi_q);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_INSERT: begin
				if (after_q && !left.after) begin
					lo_q <= ctl.lo;
					hi_q <= ctl.hi;
				end else if (left.after) begin
					lo_q <= left.lo;
					hi_q <= left.hi;
				end
			end
			OP_MERGE: begin
				if (ov_q) begin
					lo_q <= min_lo;
					hi_q <= max_hi;
				end
			end
			OP_ABSORB: begin
				if (ov_q && !left.ov) begin
					lo_q <= min_lo;
					hi_q <= right.hi;
				end else if (ov_q || after_q) begin
					lo_q <= right.lo;
					hi_q <= right.hi;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- sv/ismg_chain.sv -----
// Row of interval cells linked to their neighbors, with overlap status and read select.
// Depends on ismg_pkg and ismg_cell.
module ismg_chain (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ismg_pkg::cell_ctl_t           ctl,
	input  logic [ismg_pkg::CNT_W-1:0]    count,
	input  logic [ismg_pkg::IDX_W-1:0]    read_index,
	output ismg_pkg::chain_stat_t         stat,
	output logic [ismg_pkg::TIME_BITS-1:0] rd_lo,
	output logic [ismg_pkg::TIME_BITS-1:0] rd_hi
);
	import ismg_pkg::*;

	cell_link_t links [ENTRIES];

	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		cell_link_t left_l;
		cell_link_t right_l;
		if (k == 0) begin : g_first
			assign left_l = '0;
		end else begin : g_mid_l
			assign left_l = links[k-1];
		end
		if (k == ENTRIES - 1) begin : g_last
			assign right_l = '0;
		end else begin : g_mid_r
			assign right_l = links[k+1];
		end
		ismg_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.valid  (CNT_W'(k) < count),
			.left   (left_l),
			.right  (right_l),
			.link   (links[k])
		);
	end

	always_comb begin
		stat = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			stat.any_ov = stat.any_ov | links[k].ov;
		end
		for (int k = 0; k < ENTRIES - 1; k++) begin
			stat.multi_ov = stat.multi_ov | (links[k].ov & links[k+1].ov);
		end
	end

	assign rd_lo = links[read_index].lo;
	assign rd_hi = links[read_index].hi;

endmodule

// ----- sv/interval_set_insert_merge.sv -----
// Top level of the interval set: command handshake, sequencing of insert passes, result registers.
// Depends on ismg_pkg and ismg_chain.
//
//   channel   handshake        fields
//   command   start / busy     action, start_time, end_time, read_index
//   result    done (strobe)    entry_start, entry_end, entry_present, interval_count,
//                              overflow, bad_order
//
// Clear, read, unused codes and reversed inserts are answered from idle in the next cycle; busy stays low.
// A valid insert runs a compare step and an apply pass, then one more compare and apply pass
// for each stored interval it absorbs beyond the first, since the cell row folds one neighbor
// per compare-and-shift pass. The result appears on the cycle after the last pass, for one cycle only.
// Reset empties the list; stored interval values are not cleared.
module interval_set_insert_merge (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     action,
	input  logic [ismg_pkg::TIME_BITS-1:0] start_time,
	input  logic [ismg_pkg::TIME_BITS-1:0] end_time,
	input  logic [ismg_pkg::IDX_W-1:0]     read_index,
	output logic                           done,
	output logic [ismg_pkg::TIME_BITS-1:0] entry_start,
	output logic [ismg_pkg::TIME_BITS-1:0] entry_end,
	output logic                           entry_present,
	output logic [ismg_pkg::CNT_W-1:0]     interval_count,
	output logic                           overflow,
	output logic                           bad_order
);
	import ismg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CMP   = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	state_t               state_q;
	logic [TIME_BITS-1:0] lo_q;
	logic [TIME_BITS-1:0] hi_q;
	logic [CNT_W-1:0]     count_q;
	logic                 done_q;
	logic [TIME_BITS-1:0] entry_start_q;
	logic [TIME_BITS-1:0] entry_end_q;
	logic                 entry_present_q;
	logic [CNT_W-1:0]     interval_count_q;
	logic                 overflow_q;
	logic                 bad_order_q;

	action_t              act;
	logic                 accept;
	logic                 reversed;
	logic                 full;
	logic                 present;
	cell_ctl_t            ctl;
	chain_stat_t          stat;
	logic [TIME_BITS-1:0] rd_lo;
	logic [TIME_BITS-1:0] rd_hi;

	assign act      = action_t'(action);
	assign busy     = state_q != ST_IDLE;
	assign accept   = start && !busy;
	assign reversed = start_time > end_time;
	assign full     = count_q == CNT_W'(ENTRIES);
	assign present  = CNT_W'(read_index) < count_q;

	always_comb begin
		ctl.cmp_en = (accept && act == ACT_INSERT && !reversed) || state_q == ST_CMP;
		ctl.lo     = (state_q == ST_IDLE) ? start_time : lo_q;
		ctl.hi     = (state_q == ST_IDLE) ? end_time : hi_q;
		ctl.op     = OP_HOLD;
		if (state_q == ST_APPLY) begin
			if (!stat.any_ov) begin
				ctl.op = full ? OP_HOLD : OP_INSERT;
			end else if (stat.multi_ov) begin
				ctl.op = OP_ABSORB;
			end else begin
				ctl.op = OP_MERGE;
			end
		end
	end

	ismg_chain u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.count      (count_q),
		.read_index (read_index),
		.stat       (stat),
		.rd_lo      (rd_lo),
		.rd_hi      (rd_hi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			count_q          <= '0;
			done_q           <= 1'b0;
			lo_q             <= '0;
			hi_q             <= '0;
			entry_start_q    <= '0;
			entry_end_q      <= '0;
			entry_present_q  <= 1'b0;
			interval_count_q <= '0;
			overflow_q       <= 1'b0;
			bad_order_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					done_q <= accept && !(act == ACT_INSERT && !reversed);
					if (accept) begin
						overflow_q <= 1'b0;
						case (act)
							ACT_CLEAR: begin
								count_q          <= '0;
								entry_start_q    <= '0;
								entry_end_q      <= '0;
								entry_present_q  <= 1'b0;
								interval_count_q <= '0;
								bad_order_q      <= 1'b0;
							end
							ACT_INSERT: begin
								entry_start_q    <= '0;
								entry_end_q      <= '0;
								entry_present_q  <= 1'b0;
								interval_count_q <= count_q;
								bad_order_q      <= reversed;
								if (!reversed) begin
									lo_q    <= start_time;
									hi_q    <= end_time;
									state_q <= ST_APPLY;
								end
							end
							ACT_READ: begin
								entry_start_q    <= present ? rd_lo : '0;
								entry_end_q      <= present ? rd_hi : '0;
								entry_present_q  <= present;
								interval_count_q <= count_q;
								bad_order_q      <= 1'b0;
							end
							default: begin
								entry_start_q    <= '0;
								entry_end_q      <= '0;
								entry_present_q  <= 1'b0;
								interval_count_q <= count_q;
								bad_order_q      <= 1'b0;
							end
						endcase
					end
				end
				ST_CMP: begin
					done_q  <= 1'b0;
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (stat.any_ov && stat.multi_ov) begin
						done_q  <= 1'b0;
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_CMP;
					end else begin
						done_q     <= 1'b1;
						state_q    <= ST_IDLE;
						overflow_q <= !stat.any_ov && full;
						if (!stat.any_ov && !full) begin
							count_q          <= count_q + CNT_W'(1);
							interval_count_q <= count_q + CNT_W'(1);
						end else begin
							interval_count_q <= count_q;
						end
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign entry_start    = entry_start_q;
	assign entry_end      = entry_end_q;
	assign entry_present  = entry_present_q;
	assign interval_count = interval_count_q;
	assign overflow       = overflow_q;
	assign bad_order      = bad_order_q;

endmodule

// ----- sv/ismg_check.sv -----
// Port-level checker for the interval set, attached to the top level by a bind.
// Depends on ismg_pkg and interval_set_insert_merge.
module ismg_check (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic [1:0]                     action,
	input logic [ismg_pkg::TIME_BITS-1:0] start_time,
	input logic [ismg_pkg::TIME_BITS-1:0] end_time,
	input logic                           done,
	input logic                           entry_present,
	input logic [ismg_pkg::CNT_W-1:0]     interval_count,
	input logic                           overflow,
	input logic                           bad_order
);
	import ismg_pkg::*;

	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action != ACT_INSERT) |=> (done && !busy))
		else $error("non-insert transfer gave no result on the next cycle");

	a_reversed: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_INSERT && start_time > end_time) |=> (done && bad_order))
		else $error("reversed insert not flagged");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_CLEAR) |=> (interval_count == '0 && !entry_present))
		else $error("clear did not empty the list");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!(overflow && bad_order) && interval_count <= CNT_W'(ENTRIES)))
		else $error("inconsistent result flags or count");

endmodule

bind interval_set_insert_merge ismg_check u_ismg_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.action         (action),
	.start_time     (start_time),
	.end_time       (end_time),
	.done           (done),
	.entry_present  (entry_present),
	.interval_count (interval_count),
	.overflow       (overflow),
	.bad_order      (bad_order)
);
